FILE: src/krt_pkg.sv
`timescale 1ns / 1ps
package krt_pkg;

  // Field widths fixed by the record format
  localparam int TABLE_DEPTH_DEF = 128;
  localparam int CMD_W           = 2;
  localparam int KEY_W           = 31;
  localparam int WORD_W          = 64;
  localparam int GRADE_W         = 16;
  localparam int INDEX_W         = 7;
  localparam int STAT_W          = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [WORD_W-1:0]  dept;
    logic [WORD_W-1:0]  name;
    logic [GRADE_W-1:0] grade;
  } record_t;

  // Which result the output register captures
  typedef enum logic [1:0] {
    OSEL_INS_OK,
    OSEL_FULL,
    OSEL_MISS,
    OSEL_HIT
  } out_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DEL_READ,
    S_DEL_WRITE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     scan_step;
    logic     ins_write;
    logic     rd_last;
    logic     del_write;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_fire;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic hit;
    logic scan_miss;
  } dp_stat_t;

endpackage

FILE: src/krt_ctrl.sv
`timescale 1ns / 1ps
module krt_ctrl
  import krt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.out_sel = OSEL_MISS;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_INSERT: begin
            cmd.out_load = 1'b1;
            cmd.out_fire = 1'b1;
            if (stat.full) begin
              cmd.out_sel = OSEL_FULL;
            end else begin
              cmd.ins_write = 1'b1;
              cmd.out_sel   = OSEL_INS_OK;
            end
            state_nxt = S_IDLE;
          end
          CMD_LOOKUP, CMD_DELETE: begin
            state_nxt = S_SCAN;
          end
          default: begin
            cmd.out_load = 1'b1;
            cmd.out_fire = 1'b1;
            cmd.out_sel  = OSEL_MISS;
            state_nxt    = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_HIT;
          if (stat.cmd == CMD_DELETE) begin
            state_nxt = S_DEL_READ;
          end else begin
            cmd.out_fire = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (stat.scan_miss) begin
          cmd.out_load = 1'b1;
          cmd.out_fire = 1'b1;
          cmd.out_sel  = OSEL_MISS;
          state_nxt    = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DEL_READ: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_DEL_WRITE;
      end
      S_DEL_WRITE: begin
        cmd.del_write = 1'b1;
        cmd.out_fire  = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/krt_dpath.sv
`timescale 1ns / 1ps
module krt_dpath
  import krt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [WORD_W-1:0]  in_department_word,
  input  logic [WORD_W-1:0]  in_name_word,
  input  logic [GRADE_W-1:0] in_grade_in,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [INDEX_W-1:0] out_entry_index,
  output logic [KEY_W-1:0]   out_key_out,
  output logic [WORD_W-1:0]  out_department_out,
  output logic [WORD_W-1:0]  out_name_out,
  output logic [GRADE_W-1:0] out_grade_out
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  cmd_t                cmd_r;
  logic [KEY_W-1:0]    key_r;
  record_t             rec_in_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       scan_r;
  logic                cmp_valid_r;
  logic [IW-1:0]       cmp_idx_r;
  record_t             rd_data_r;
  record_t             mem [TABLE_DEPTH];

  logic                issue_ok;
  logic [CW-1:0]       last_idx;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  record_t             wr_data;
  logic                rd_en;
  logic [IW-1:0]       rd_addr;

  logic                out_valid_r;
  status_t             status_r;
  logic [INDEX_W-1:0]  index_r;
  logic [KEY_W-1:0]    key_out_r;
  logic [WORD_W-1:0]   dept_out_r;
  logic [WORD_W-1:0]   name_out_r;
  logic [GRADE_W-1:0]  grade_out_r;

  assign issue_ok = (scan_r < count_r);
  assign last_idx = count_r - CW'(1);

  assign stat.cmd       = cmd_r;
  assign stat.full      = (count_r == CW'(TABLE_DEPTH));
  assign stat.hit       = cmp_valid_r && (rd_data_r.key == key_r);
  assign stat.scan_miss = !cmp_valid_r && !issue_ok;

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r          <= cmd_t'(in_command);
      key_r          <= in_key;
      rec_in_r.key   <= in_key;
      rec_in_r.dept  <= in_department_word;
      rec_in_r.name  <= in_name_word;
      rec_in_r.grade <= in_grade_in;
    end
  end

  // Track live records
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.ins_write) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.del_write) begin
      count_r <= last_idx;
    end
  end

  // Scan pointer: issue one read a cycle, compare the previous one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_valid_r <= 1'b0;
      scan_r      <= '0;
    end else if (cmd.load) begin
      cmp_valid_r <= 1'b0;
      scan_r      <= '0;
    end else if (cmd.scan_step) begin
      cmp_valid_r <= issue_ok;
      if (issue_ok) begin
        scan_r <= scan_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      cmp_idx_r <= scan_r[IW-1:0];
    end
  end

  // Record memory: one write port, one registered read port
  assign wr_en   = cmd.ins_write || cmd.del_write;
  assign wr_addr = cmd.ins_write ? count_r[IW-1:0] : cmp_idx_r;
  assign wr_data = cmd.ins_write ? rec_in_r : rd_data_r;
  assign rd_en   = (cmd.scan_step && issue_ok) || cmd.rd_last;
  assign rd_addr = cmd.rd_last ? last_idx[IW-1:0] : scan_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OSEL_INS_OK: begin
          status_r    <= ST_OK;
          index_r     <= INDEX_W'(count_r);
          key_out_r   <= key_r;
          dept_out_r  <= rec_in_r.dept;
          name_out_r  <= rec_in_r.name;
          grade_out_r <= rec_in_r.grade;
        end
        OSEL_HIT: begin
          status_r    <= ST_OK;
          index_r     <= INDEX_W'(cmp_idx_r);
          key_out_r   <= rd_data_r.key;
          dept_out_r  <= rd_data_r.dept;
          name_out_r  <= rd_data_r.name;
          grade_out_r <= rd_data_r.grade;
        end
        OSEL_FULL: begin
          status_r    <= ST_FULL;
          index_r     <= '0;
          key_out_r   <= key_r;
          dept_out_r  <= '0;
          name_out_r  <= '0;
          grade_out_r <= '0;
        end
        default: begin
          status_r    <= ST_MISS;
          index_r     <= '0;
          key_out_r   <= key_r;
          dept_out_r  <= '0;
          name_out_r  <= '0;
          grade_out_r <= '0;
        end
      endcase
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_fire;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_entry_index    = index_r;
  assign out_key_out        = key_out_r;
  assign out_department_out = dept_out_r;
  assign out_name_out       = name_out_r;
  assign out_grade_out      = grade_out_r;

endmodule

FILE: src/keyed_record_table.sv
`timescale 1ns / 1ps
// Dense unordered record table. Pulse start while busy is low to issue a
// transaction (insert, lookup or delete by key); exactly one result comes back
// with a one-cycle out_valid strobe that cannot be held off, so capture it
// when it appears. Lookup and delete walk the keys one entry per cycle through
// the single memory read port. Delete fills the freed slot with the last
// record, so record order is not kept. busy drops in the cycle the result is
// shown, and a new start may be given in that same cycle.
module keyed_record_table
  import krt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [WORD_W-1:0]  in_department_word,
  input  logic [WORD_W-1:0]  in_name_word,
  input  logic [GRADE_W-1:0] in_grade_in,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [INDEX_W-1:0] out_entry_index,
  output logic [KEY_W-1:0]   out_key_out,
  output logic [WORD_W-1:0]  out_department_out,
  output logic [WORD_W-1:0]  out_name_out,
  output logic [GRADE_W-1:0] out_grade_out
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  krt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (dp_stat),
    .cmd   (dp_cmd)
  );

  krt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_command         (in_command),
    .in_key             (in_key),
    .in_department_word (in_department_word),
    .in_name_word       (in_name_word),
    .in_grade_in        (in_grade_in),
    .cmd                (dp_cmd),
    .stat               (dp_stat),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_entry_index    (out_entry_index),
    .out_key_out        (out_key_out),
    .out_department_out (out_department_out),
    .out_name_out       (out_name_out),
    .out_grade_out      (out_grade_out)
  );

  // A result is shown only as the block returns to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // An accepted transaction keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // Results never come back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result strobes in a row");

  // Miss and full results carry index zero and no payload
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_MISS || out_status == ST_FULL)) |->
      (out_entry_index == '0 && out_grade_out == '0))
    else $error("rejected transaction carries record data");

endmodule
